### sv/peak_normalized_histogram_top_defines.svh
// Assertion macros for the peak-normalised histogram.
`ifndef PEAK_NORMALIZED_HISTOGRAM_TOP_DEFINES_SVH
`define PEAK_NORMALIZED_HISTOGRAM_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PNH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pnh_pkg.sv
// Types and constants shared by the peak-normalised histogram modules.
`default_nettype none
package pnh_pkg;

  localparam int BINS    = 2048;
  localparam int BIN_W   = $clog2(BINS);
  localparam int COUNT_W = 32;
  localparam int SPAN_W  = BIN_W + 1;
  localparam int SUM_W   = COUNT_W + BIN_W;
  localparam int DEN_W   = COUNT_W + SPAN_W;
  localparam int FRAC_W  = 16;
  localparam int LEVEL_W = FRAC_W + 1;
  localparam int DIV_W   = DEN_W + FRAC_W + 1;
  localparam int STEP_W  = 5;
  localparam int QSHIFT  = FRAC_W - BIN_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_SAMPLE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OUT_RANGE = 2'd1;
  localparam logic [1:0] STAT_BAD_RANGE = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  localparam logic REG_RANGE_LOW  = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_QSUM,
    ST_QDRAIN,
    ST_QMUL,
    ST_QSTART,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] sample_value;
    logic [15:0]        query_start;
    logic [15:0]        query_end;
  } in_word_t;

  typedef struct packed {
    logic [16:0] level;
    logic [10:0] bin_index;
    logic [31:0] peak_value;
    logic [1:0]  status;
  } out_word_t;

endpackage
`default_nettype wire

### sv/pnh_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module pnh_ram #(
  parameter int DEPTH = 2048,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/pnh_div.sv
// Restoring divider, one quotient bit per cycle, shared by sample binning and queries.
`default_nettype none
module pnh_div import pnh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_W-1:0]   dividend,
  input  wire logic [DIV_W-1:0]   divisor,
  input  wire logic [STEP_W-1:0]  steps,
  output logic                    done,
  output logic      [LEVEL_W-1:0] quotient
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              ge;

  // The divisor enters already shifted to the top quotient bit.
  assign ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      dvs      <= dvs >> 1;
      quotient <= {quotient[LEVEL_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### sv/peak_normalized_histogram_top.sv
// Top level of the peak-normalised histogram engine.
// Usage: words enter on in_valid/in_ready and each produces exactly one result
// word on out_valid/out_ready. Items are handled one at a time; in_ready is high
// while the engine is idle, also while an earlier result still waits in the
// output register.
// Steps per word from acceptance to the next acceptance, set by the bin-count
// RAM port and the one-bit-per-cycle divider (the result word appears in the same
// cycle as the next word can be taken):
//   sample in range: accept, check, 11 divider steps and a completion
//   step, read, update, reply;
//   sample dropped: accept, check, reply; unused action: accept, reply;
//   query: accept, one RAM read per bin spanned, drain, multiply, divider start,
//   17 divider steps and a completion step, reply; accept, reply when empty or reversed;
//   clear: accept, one bin written per cycle over all 2048 bins, reply.
// Reset (rst, synchronous) starts the same clearing pass over all 2048 bins;
// no word is accepted until the pass ends, while configuration writes are taken.
// A stalled receiver holds the result in the output register; the engine then
// finishes its next word and waits until the register is free.
// range_low and range_high are written through the APB port at 0x0 and 0x4.
`default_nettype none
`include "peak_normalized_histogram_top_defines.svh"
module peak_normalized_histogram_top import pnh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_word,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  state_t state, state_next;

  logic signed [31:0] range_low, range_high;
  logic [BIN_W-1:0]   ptr, b0, b1, bin;
  logic               clr_reply, pend;
  logic [1:0]         act;
  logic signed [31:0] x;
  logic [SUM_W-1:0]   sum;
  logic [DEN_W-1:0]   den;
  logic [COUNT_W-1:0] peak;
  logic [LEVEL_W-1:0] res_level;
  logic [BIN_W-1:0]   res_bin;
  logic [1:0]         res_status;

  logic               accept, out_free;
  logic signed [32:0] rl33, rh33, x33;
  logic               bad_range, out_range;
  logic [31:0]        span, diff;
  logic [BIN_W-1:0]   q0, q1;
  logic [SPAN_W-1:0]  nbins;
  logic [COUNT_W-1:0] cnt_new;

  logic               ram_we, ram_re;
  logic [BIN_W-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dividend, div_divisor;
  logic [STEP_W-1:0]  div_steps;
  logic [LEVEL_W-1:0] div_q;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANGE_LOW) ? range_low : range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= 32'sd65536;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_RANGE_LOW) begin
        range_low <= pwdata;
      end else begin
        range_high <= pwdata;
      end
    end
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Sample range checks, all on 33 bits so nothing wraps.
  assign rl33      = {range_low[31], range_low};
  assign rh33      = {range_high[31], range_high};
  assign x33       = {x[31], x};
  assign bad_range = (rh33 <= rl33);
  assign out_range = (x33 < rl33) || (x33 >= rh33);
  assign span      = 32'(rh33 - rl33);
  assign diff      = 32'(x33 - rl33);

  assign q0      = in_word.query_start[FRAC_W-1:QSHIFT];
  assign q1      = in_word.query_end[FRAC_W-1:QSHIFT];
  assign nbins   = {1'b0, b1} - {1'b0, b0} + SPAN_W'(1);
  assign cnt_new = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

  // RAM and divider control
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = ptr;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = ptr;
    div_start    = 1'b0;
    div_dividend = DIV_W'({diff, BIN_W'(0)});
    div_divisor  = DIV_W'(span) << (BIN_W - 1);
    div_steps    = STEP_W'(BIN_W);
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_CHECK: begin
        div_start = !bad_range && !out_range;
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = bin;
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = bin;
        ram_wdata = cnt_new;
      end
      ST_QSUM: begin
        ram_re = 1'b1;
      end
      ST_QSTART: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({sum, FRAC_W'(0)});
        div_divisor  = DIV_W'(den) << FRAC_W;
        div_steps    = STEP_W'(LEVEL_W);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr == BIN_W'(BINS - 1)) begin
          state_next = clr_reply ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_word.action)
            ACT_CLEAR:  state_next = ST_CLEAR;
            ACT_SAMPLE: state_next = ST_CHECK;
            ACT_QUERY: begin
              if (q0 > q1 || peak == '0) begin
                state_next = ST_RESP;
              end else begin
                state_next = ST_QSUM;
              end
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_CHECK:  state_next = div_start ? ST_DIV : ST_RESP;
      ST_DIV: begin
        if (div_done) begin
          state_next = (act == ACT_SAMPLE) ? ST_READ : ST_RESP;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_QSUM: begin
        if (ptr == b1) begin
          state_next = ST_QDRAIN;
        end
      end
      ST_QDRAIN: state_next = ST_QMUL;
      ST_QMUL:   state_next = ST_QSTART;
      ST_QSTART: state_next = ST_DIV;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      clr_reply <= 1'b0;
      peak      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          ptr  <= ptr + 1'b1;
          peak <= '0;
        end
        ST_IDLE: begin
          if (accept) begin
            clr_reply <= 1'b1;
            ptr       <= (in_word.action == ACT_CLEAR) ? '0 : q0;
          end
        end
        ST_UPDATE: begin
          if (cnt_new > peak) begin
            peak <= cnt_new;
          end
        end
        ST_QSUM: begin
          if (ptr != b1) begin
            ptr <= ptr + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        act        <= in_word.action;
        x          <= in_word.sample_value;
        b0         <= q0;
        b1         <= q1;
        sum        <= '0;
        pend       <= 1'b0;
        res_level  <= '0;
        res_bin    <= '0;
        res_status <= (in_word.action == ACT_QUERY && (q0 > q1 || peak == '0))
                      ? STAT_EMPTY : STAT_OK;
      end
      ST_CHECK: begin
        if (bad_range) begin
          res_status <= STAT_BAD_RANGE;
        end else if (out_range) begin
          res_status <= STAT_OUT_RANGE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (act == ACT_SAMPLE) begin
            bin <= div_q[BIN_W-1:0];
          end else begin
            res_level <= div_q;
          end
        end
      end
      ST_UPDATE: begin
        res_bin <= bin;
      end
      ST_QSUM: begin
        pend <= 1'b1;
        if (pend) begin
          sum <= sum + SUM_W'(ram_rdata);
        end
      end
      ST_QDRAIN: begin
        sum <= sum + SUM_W'(ram_rdata);
      end
      ST_QMUL: begin
        den <= DEN_W'(peak) * DEN_W'(nbins);
      end
      ST_RESP: begin
        if (out_free) begin
          out_word.level      <= res_level;
          out_word.bin_index  <= res_bin;
          out_word.peak_value <= peak;
          out_word.status     <= res_status;
        end
      end
      default: begin
      end
    endcase
  end

  pnh_ram #(
    .DEPTH (BINS),
    .DW    (COUNT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pnh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  `PNH_ASSERT_SAME(a_level_ok, out_valid && (out_word.level != '0), out_word.status == STAT_OK, "non-zero level with error status")
  `PNH_ASSERT_SAME(a_bin_ok, out_valid && (out_word.status != STAT_OK), out_word.bin_index == '0, "bin index set on dropped word")
  `PNH_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "word accepted while busy")

endmodule
`default_nettype wire

### sim/tb_peak_normalized_histogram_top.sv
// Self-checking testbench for the peak-normalised histogram engine.
`default_nettype none
module tb_peak_normalized_histogram_top;
  import pnh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED      = 2'd3;
  localparam logic [2:0] ADDR_RANGE_LOW  = 3'd0;
  localparam logic [2:0] ADDR_RANGE_HIGH = 3'd4;
  localparam int         HOLD_CYCLES     = 600;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  peak_normalized_histogram_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Histogram model state and its copy of the range registers.
  logic [31:0]        tally [BINS];
  logic [31:0]        tally_peak;
  logic signed [31:0] model_low;
  logic signed [31:0] model_high;

  in_word_t  queued_words[$];
  out_word_t pending_results[$];
  logic      word_taken;
  logic      no_idle;
  int        hold_requests;
  int        holds_started;
  int        hold_left;
  int        mismatches;
  int        results_seen;
  int        phases_run;

  function automatic out_word_t predict_histogram(in_word_t w);
    out_word_t   r;
    longint      x, lo, hi;
    logic [63:0] span, diff, b, sum, den, lvl;
    int          b0, b1;
    r = '0;
    case (w.action)
      ACT_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        tally_peak = '0;
      end
      ACT_SAMPLE: begin
        x  = longint'($signed(w.sample_value));
        lo = longint'(model_low);
        hi = longint'(model_high);
        if (hi <= lo) begin
          r.status = STAT_BAD_RANGE;
        end else if (x < lo || x >= hi) begin
          r.status = STAT_OUT_RANGE;
        end else begin
          span = 64'(hi - lo);
          diff = 64'(x - lo);
          b = (64'(BINS) * diff) / span;
          if (b >= 64'(BINS)) begin
            r.status = STAT_OUT_RANGE;
          end else begin
            if (tally[b] != COUNT_MAX) tally[b] = tally[b] + 1;
            if (tally[b] > tally_peak) tally_peak = tally[b];
            r.bin_index = b[10:0];
          end
        end
      end
      ACT_QUERY: begin
        b0 = int'((64'(BINS) * 64'(w.query_start)) >> 16);
        b1 = int'((64'(BINS) * 64'(w.query_end)) >> 16);
        if (b0 > b1 || b1 >= BINS || tally_peak == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          sum = '0;
          for (int i = b0; i <= b1; i++) sum = sum + 64'(tally[i]);
          den = 64'(tally_peak) * 64'(b1 - b0 + 1);
          lvl = (sum << 16) / den;
          r.level = lvl[16:0];
        end
      end
      default: ;
    endcase
    r.peak_value = tally_peak;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: one nonblocking write per signal per falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (queued_words.size() > 0 && (no_idle || $urandom_range(0, 99) >= 7)) begin
        in_word  <= queued_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    word_taken <= 1'b0;
  end

  // Receiver, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_started < hold_requests) begin
      out_ready     <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && in_valid && in_ready) begin
      pending_results.push_back(predict_histogram(in_word));
      word_taken <= 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", out_word);
      end else begin
        want = pending_results.pop_front();
        if (out_word.level !== want.level || out_word.bin_index !== want.bin_index ||
            out_word.peak_value !== want.peak_value || out_word.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected level %0d bin %0d peak %0d status %0d, got %0d %0d %0d %0d",
                     want.level, want.bin_index, want.peak_value, want.status,
                     out_word.level, out_word.bin_index, out_word.peak_value, out_word.status);
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (queued_words.size() > 0 || in_valid || pending_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_range(input logic signed [31:0] lo, input logic signed [31:0] hi);
    wait_drained();
    apb_write(ADDR_RANGE_LOW, lo);
    apb_write(ADDR_RANGE_HIGH, hi);
    model_low  = lo;
    model_high = hi;
    phases_run++;
  endtask

  function automatic in_word_t make_word(input logic [1:0] act, input logic [31:0] x,
                                         input logic [15:0] qs, input logic [15:0] qe);
    in_word_t w;
    w.action = act; w.sample_value = x; w.query_start = qs; w.query_end = qe;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int          pick;
    logic [63:0] span;
    w = make_word(ACT_SAMPLE, $urandom, 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 999);
    span = 64'(longint'(model_high) - longint'(model_low));
    if (pick < 8) begin
      w.action = ACT_CLEAR;
    end else if (pick < 40) begin
      w.action = ACT_UNUSED;
    end else if (pick < 720) begin
      case ($urandom_range(0, 9))
        0: w.sample_value = model_low - $urandom_range(0, 1);
        1: w.sample_value = model_high - $urandom_range(0, 1);
        2: ;
        default:
          if (model_high > model_low)
            w.sample_value = 32'(longint'(model_low) + longint'({$urandom, $urandom} % span));
      endcase
    end else begin
      w.action = ACT_QUERY;
      case ($urandom_range(0, 19))
        0: ;
        1: begin w.query_start = 16'h0000; w.query_end = 16'hFFFF; end
        default: w.query_end = 16'(w.query_start + $urandom_range(0, 40 * 32));
      endcase
      // Full-width queries walk every bin, so keep them rare.
      if (w.query_end > w.query_start && (w.query_end - w.query_start) > 16'd2048 &&
          $urandom_range(0, 29) != 0)
        w.query_end = w.query_start + 16'($urandom_range(0, 2047));
    end
    return w;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) queued_words.push_back(random_word());
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; in_word = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    word_taken = 1'b0; no_idle = 1'b0;
    hold_requests = 0; holds_started = 0; hold_left = 0;
    mismatches = 0; results_seen = 0; phases_run = 0;
    foreach (tally[i]) tally[i] = '0;
    tally_peak = '0; model_low = 0; model_high = 65536;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words with the reset range.
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'h0000, 16'hFFFF));
    queued_words.push_back(make_word(ACT_SAMPLE, 0, 0, 0));
    queued_words.push_back(make_word(ACT_SAMPLE, 65535, 0, 0));
    queued_words.push_back(make_word(ACT_SAMPLE, 32'hFFFF_FFFF, 0, 0));
    queued_words.push_back(make_word(ACT_SAMPLE, 65536, 0, 0));
    queued_words.push_back(make_word(ACT_SAMPLE, 32'h8000_0000, 0, 0));
    queued_words.push_back(make_word(ACT_SAMPLE, 32'h7FFF_FFFF, 0, 0));
    for (int i = 0; i < 4; i++) queued_words.push_back(make_word(ACT_SAMPLE, 40, 0, 0));
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'h0000, 16'hFFFF));
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'h0000, 16'h001F));
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'hFFE0, 16'hFFFF));
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'h0400, 16'h0100));
    queued_words.push_back(make_word(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    queued_words.push_back(make_word(ACT_CLEAR, 0, 0, 0));
    queued_words.push_back(make_word(ACT_QUERY, 0, 16'h0000, 16'h0000));
    queued_words.push_back(make_word(ACT_SAMPLE, 1, 0, 0));

    set_range(0, 2048);
    random_phase(150);
    // Fill the engine while the receiver is held off.
    wait_drained();
    hold_requests = 1;
    random_phase(20);
    set_range(32'sh8000_0000, 32'sh7FFF_FFFF);
    random_phase(120);
    set_range(-1000, 1000);
    no_idle = 1'b1;
    random_phase(150);
    wait_drained();
    no_idle = 1'b0;
    set_range(500, 500);
    random_phase(30);
    set_range(700, -700);
    random_phase(30);
    set_range(100, 103);
    random_phase(120);
    set_range(-5, 100000);
    random_phase(150);
    set_range(0, 65536);
    random_phase(160);

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Ran %0d range settings, %0d result words checked, %0d mismatches.",
             phases_run, results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d result words outstanding.", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+sv
sv/pnh_pkg.sv
sv/pnh_ram.sv
sv/pnh_div.sv
sv/peak_normalized_histogram_top.sv
sim/tb_peak_normalized_histogram_top.sv
